### rtl/crc16_modbus_frame_packer_macros.svh
// ----------------------------------------------------------------------------
// CRC-16/MODBUS frame packer assertion macros
// Shared assertion wrappers clocked on clk; CMFP_ASSERT is disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CRC16_MODBUS_FRAME_PACKER_MACROS_SVH
`define CRC16_MODBUS_FRAME_PACKER_MACROS_SVH

// Check a property outside of reset.
`define CMFP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define CMFP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/crc16m_pkg.sv
// ----------------------------------------------------------------------------
// crc16m_pkg
// Types, constants and the byte fold function of the CRC-16/MODBUS packer.
// ----------------------------------------------------------------------------
package crc16m_pkg;

	localparam int unsigned WordW = 16;
	localparam int unsigned ByteW = 8;
	localparam logic [WordW-1:0] CrcPoly = 16'hA001;
	localparam logic [WordW-1:0] CrcSeedReset = 16'hFFFF;

	typedef enum logic [1:0] {
		PH_LO,
		PH_HI,
		PH_CRC_LO,
		PH_CRC_HI
	} phase_t;

	typedef struct packed {
		logic             fold;
		logic             close;
		logic [ByteW-1:0] data;
	} crc_ctl_t;

	typedef struct packed {
		logic [ByteW-1:0] data;
		logic             is_crc;
		logic             frame_end;
	} out_item_t;

	// Fold one byte into a reflected CRC, LSB first.
	function automatic logic [WordW-1:0] fold_byte(input logic [WordW-1:0] crc,
			input logic [ByteW-1:0] b);
		logic [WordW-1:0] c;
		c = crc ^ {{(WordW-ByteW){1'b0}}, b};
		for (int k = 0; k < ByteW; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CrcPoly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

### rtl/crc16m_crc_unit.sv
// ----------------------------------------------------------------------------
// crc16m_crc_unit
// Running CRC register: folds one byte per command and reloads at frame end.
// ----------------------------------------------------------------------------
module crc16m_crc_unit
	import crc16m_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [WordW-1:0] crc_seed,
	input  crc_ctl_t         ctl,
	output logic [WordW-1:0] crc
);

	logic [WordW-1:0] crc_q;
	logic             in_frame_q;
	logic [WordW-1:0] crc_src;

	// First byte of a frame starts from the live seed.
	assign crc_src = in_frame_q ? crc_q : crc_seed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= CrcSeedReset;
			in_frame_q <= 1'b0;
		end else if (ctl.fold) begin
			crc_q      <= fold_byte(crc_src, ctl.data);
			in_frame_q <= 1'b1;
		end else if (ctl.close) begin
			crc_q      <= crc_seed;
			in_frame_q <= 1'b0;
		end
	end

	assign crc = crc_q;

endmodule

### rtl/crc16m_out_stage.sv
// ----------------------------------------------------------------------------
// crc16m_out_stage
// Output register of the byte stream with its handshake.
// ----------------------------------------------------------------------------
module crc16m_out_stage
	import crc16m_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  out_item_t        item,
	output logic             ready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [ByteW-1:0] m_tdata,
	output logic             m_tuser,
	output logic             m_tlast
);

	logic      valid_q;
	out_item_t item_q;

	assign ready = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load) begin
			item_q <= item;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = item_q.data;
	assign m_tuser  = item_q.is_crc;
	assign m_tlast  = item_q.frame_end;

endmodule

### rtl/crc16_modbus_frame_packer.sv
// A word passes through the input register and then the output register before its first byte appears.
// Throughput: one byte per cycle while m_tready allows; a word gives two bytes, a last word four
// (two payload bytes plus the two CRC trailer bytes).
// The byte sequencer and its one-byte fold per cycle set that figure.
// Reset: arst_n clears all control state at once; seed returns to 0xFFFF.
// ----------------------------------------------------------------------------
// crc16_modbus_frame_packer
// Splits 16-bit words into bytes, low byte first, folds each into a
// CRC-16/MODBUS and appends the CRC (low, then high byte) after the last word.
// ----------------------------------------------------------------------------
`include "crc16_modbus_frame_packer_macros.svh"

module crc16_modbus_frame_packer
	import crc16m_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// configuration: crc_seed
	input  logic             cfg_we,
	input  logic [WordW-1:0] cfg_wdata,
	// input stream
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [WordW-1:0] s_tdata,   // [15:0] word_value
	input  logic             s_tlast,   // last_word
	// output stream
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [ByteW-1:0] m_tdata,   // [7:0] out_byte
	output logic             m_tuser,   // [0] is_crc
	output logic             m_tlast    // frame_end
);

	logic [WordW-1:0] crc_seed_q;

	logic             in_valid_s1;
	logic [WordW-1:0] word_s1;
	logic             last_s1;

	phase_t           phase_q;
	phase_t           phase_d;

	logic             out_ready;
	logic             adv;
	logic             item_done;
	crc_ctl_t         crc_ctl;
	out_item_t        out_item;
	logic [WordW-1:0] crc;

	// Seed register; takes effect at the next frame start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_seed_q <= CrcSeedReset;
		end else if (cfg_we) begin
			crc_seed_q <= cfg_wdata;
		end
	end

	// Advance one byte whenever a word is held and the output register can take it.
	assign adv       = in_valid_s1 && out_ready;
	assign item_done = (phase_q == PH_HI && !last_s1) || (phase_q == PH_CRC_HI);

	// Free the input register on the final byte of the held word.
	assign s_tready = !in_valid_s1 || (adv && item_done);

	// Input register: one word, held until all its bytes are out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			word_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Byte sequencer: next state.
	always_comb begin
		phase_d = phase_q;
		if (adv) begin
			if (item_done) begin
				phase_d = PH_LO;
			end else begin
				unique case (phase_q)
					PH_LO:     phase_d = PH_HI;
					PH_HI:     phase_d = PH_CRC_LO;
					PH_CRC_LO: phase_d = PH_CRC_HI;
					default:   phase_d = PH_LO;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LO;
		end else begin
			phase_q <= phase_d;
		end
	end

	// Byte sequencer: outputs. Payload bytes fold into the CRC; the CRC
	// high byte closes the frame and reloads the seed.
	always_comb begin
		crc_ctl            = '0;
		out_item.data      = word_s1[ByteW-1:0];
		out_item.is_crc    = 1'b0;
		out_item.frame_end = 1'b0;
		unique case (phase_q)
			PH_LO: begin
				out_item.data = word_s1[ByteW-1:0];
				crc_ctl.fold  = adv;
				crc_ctl.data  = word_s1[ByteW-1:0];
			end
			PH_HI: begin
				out_item.data = word_s1[WordW-1:ByteW];
				crc_ctl.fold  = adv;
				crc_ctl.data  = word_s1[WordW-1:ByteW];
			end
			PH_CRC_LO: begin
				out_item.data   = crc[ByteW-1:0];
				out_item.is_crc = 1'b1;
			end
			PH_CRC_HI: begin
				out_item.data      = crc[WordW-1:ByteW];
				out_item.is_crc    = 1'b1;
				out_item.frame_end = 1'b1;
				crc_ctl.close      = adv;
			end
			default: begin
				crc_ctl = '0;
			end
		endcase
	end

	crc16m_crc_unit u_crc (
		.clk      (clk),
		.arst_n   (arst_n),
		.crc_seed (crc_seed_q),
		.ctl      (crc_ctl),
		.crc      (crc)
	);

	crc16m_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv),
		.item     (out_item),
		.ready    (out_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// An idle input register always restarts at the low payload byte.
	`CMFP_ASSERT(a_idle_phase, !in_valid_s1 |-> phase_q == PH_LO, "phase not reset when idle")
	// CRC trailer phases only occur for a word marked last.
	`CMFP_ASSERT(a_crc_needs_last, in_valid_s1 && (phase_q == PH_CRC_LO || phase_q == PH_CRC_HI) |-> last_s1, "CRC phase without last word")
	// A held word is never released on its first byte.
	`CMFP_ASSERT(a_no_early_release, in_valid_s1 && phase_q == PH_LO |-> !s_tready, "input freed after one byte")
	// Frame end only ever marks a CRC byte.
	`CMFP_ASSERT_ALWAYS(a_end_is_crc, m_tvalid && m_tlast |-> m_tuser, "frame end on payload byte")

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16/MODBUS frame packer testbench
// Streams payload words through the packer with random idling on both sides.
// A local CRC model predicts every output byte, and the monitor checks each
// byte against the oldest prediction. Seed writes happen only while the block
// is idle, including writes with a frame still open.
// ----------------------------------------------------------------------------
module testbench;
	import crc16m_pkg::*;

	typedef struct {
		logic [WordW-1:0] value;
		logic             last;
	} payload_word_t;

	localparam int unsigned HoldCycles = 100;  // long receiver hold-off
	localparam int unsigned HoldAfter  = 60;   // results seen before it starts
	localparam int unsigned DrainWait  = 20;   // settle time after the last byte

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [WordW-1:0] cfg_wdata = '0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [WordW-1:0] s_tdata = '0;   // [15:0] word_value
	logic             s_tlast = 1'b0; // last_word
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [ByteW-1:0] m_tdata;        // [7:0] out_byte
	logic             m_tuser;        // [0] is_crc
	logic             m_tlast;        // frame_end

	// Stimulus and expected-byte stores.
	payload_word_t pending_words[$];
	out_item_t     expected_bytes[$];

	// CRC model state.
	logic [WordW-1:0] seed_now = CrcSeedReset;
	logic [WordW-1:0] frame_crc = CrcSeedReset;
	logic             frame_open = 1'b0;

	// Idling control: random gaps on both sides while this is set.
	logic        idling_on = 1'b1;
	int unsigned tx_gap = 0;
	int unsigned rx_gap = 0;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;
	int unsigned bytes_seen = 0;
	int unsigned error_count = 0;

	crc16_modbus_frame_packer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Fold one byte into the reflected CRC, one bit per step, LSB first.
	function automatic logic [WordW-1:0] crc_fold_octet(input logic [WordW-1:0] crc,
			input logic [ByteW-1:0] octet);
		logic [WordW-1:0] c;
		logic             drop;
		c = crc;
		for (int i = 0; i < ByteW; i++) begin
			drop = c[0] ^ octet[i];
			c = c >> 1;
			if (drop) begin
				c = c ^ CrcPoly;
			end
		end
		return c;
	endfunction

	// Predict the bytes one word transaction produces: two payload bytes, and
	// the CRC trailer (low byte, then high byte) when the word closes a frame.
	task automatic predict_frame_bytes(input logic [WordW-1:0] word, input logic last);
		logic [WordW-1:0] crc;
		out_item_t        b;
		crc = frame_open ? frame_crc : seed_now;
		crc = crc_fold_octet(crc, word[7:0]);
		crc = crc_fold_octet(crc, word[15:8]);
		b.is_crc = 1'b0;
		b.frame_end = 1'b0;
		b.data = word[7:0];
		expected_bytes.push_back(b);
		b.data = word[15:8];
		expected_bytes.push_back(b);
		if (last) begin
			b.is_crc = 1'b1;
			b.data = crc[7:0];
			expected_bytes.push_back(b);
			b.data = crc[15:8];
			b.frame_end = 1'b1;
			expected_bytes.push_back(b);
			// reload from whatever seed is current at the close
			frame_crc = seed_now;
			frame_open = 1'b0;
		end else begin
			frame_crc = crc;
			frame_open = 1'b1;
		end
	endtask

	// Word driver: predict on each accepted transaction, then present the next
	// word unless an idle burst is running.
	always @(posedge clk) begin : drive_words
		payload_word_t w;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			tx_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_frame_bytes(s_tdata, s_tlast);
			end
			if (!s_tvalid || s_tready) begin
				if (tx_gap != 0) begin
					// hold the idle burst
					tx_gap <= tx_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_words.size() != 0 && idling_on
						&& $urandom_range(0, 4) == 0) begin
					// start an idle burst, loading tx_gap with a random value from 0 to 9
					tx_gap <= $urandom_range(0, 9);
					s_tvalid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					w = pending_words.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= w.value;
					s_tlast <= w.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Byte monitor: check each accepted transaction against the oldest
	// prediction, then decide whether to stall the next cycle.
	always @(posedge clk) begin : check_bytes
		out_item_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				bytes_seen <= bytes_seen + 1;
				if (expected_bytes.size() == 0) begin
					$error("unexpected byte %02h (is_crc %0b, frame_end %0b)",
						m_tdata, m_tuser, m_tlast);
					error_count = error_count + 1;
				end else begin
					want = expected_bytes.pop_front();
					if (m_tdata !== want.data) begin
						$error("out_byte: expected %02h, got %02h", want.data, m_tdata);
						error_count = error_count + 1;
					end
					if (m_tuser !== want.is_crc) begin
						$error("is_crc: expected %0b, got %0b", want.is_crc, m_tuser);
						error_count = error_count + 1;
					end
					if (m_tlast !== want.frame_end) begin
						$error("frame_end: expected %0b, got %0b", want.frame_end, m_tlast);
						error_count = error_count + 1;
					end
				end
			end
			if (hold_left != 0) begin
				m_tready <= 1'b0;
			end else if (rx_gap != 0) begin
				rx_gap <= rx_gap - 1;
				m_tready <= 1'b0;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				rx_gap <= $urandom_range(0, 9);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Long receiver hold-off, started once some traffic has gone through.
	// The sender keeps offering words, so the block backs up and drops
	// s_tready.
	always @(posedge clk) begin
		if (!hold_done && bytes_seen >= HoldAfter) begin
			hold_left <= HoldCycles;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Wait until the sender is drained and every predicted byte has arrived.
	// Checks are made on the falling edge so all edge updates have settled.
	task automatic wait_quiet();
		@(negedge clk);
		while (pending_words.size() != 0 || s_tvalid || expected_bytes.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Write the seed register while the block is idle; the model follows.
	task automatic write_seed(input logic [WordW-1:0] value);
		wait_quiet();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		seed_now = value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic queue_word(input logic [WordW-1:0] value, input logic last);
		payload_word_t w;
		w.value = value;
		w.last = last;
		pending_words.push_back(w);
	endtask

	// Random words with frame ends scattered, so a phase can finish with a
	// frame still open and the next seed write lands inside it.
	task automatic queue_random_words(input int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			queue_word(WordW'($urandom_range(0, 65535)), $urandom_range(0, 3) == 0);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset seed: single-word frame, field extremes, then leave a frame open.
		queue_word(16'h0000, 1'b1);
		queue_word(16'hFFFF, 1'b0);
		queue_word(16'h00FF, 1'b0);
		queue_word(16'hFF00, 1'b1);
		queue_word(16'h1234, 1'b0);

		// Seed change inside the open frame: the frame keeps its running CRC,
		// the new all-zero seed applies from the next frame on.
		write_seed(16'h0000);
		queue_word(16'h5555, 1'b1);
		queue_word(16'hAAAA, 1'b1);
		queue_word(16'h8001, 1'b0);
		queue_word(16'h7FFE, 1'b1);

		// Seed change between frames, back to all ones.
		write_seed(16'hFFFF);
		queue_word(16'hFFFF, 1'b1);
		queue_word(16'h0000, 1'b0);
		queue_word(16'h0000, 1'b1);

		// Random phases under several seeds; the final one runs without idling.
		write_seed(WordW'($urandom_range(0, 65535)));
		queue_random_words(30);
		write_seed(16'h0000);
		queue_random_words(30);
		write_seed(16'hFFFF);
		queue_random_words(30);
		write_seed(WordW'($urandom_range(0, 65535)));
		idling_on = 1'b0;
		queue_random_words(30);

		wait_quiet();
		repeat (DrainWait) @(posedge clk);
		@(negedge clk);
		if (error_count == 0 && expected_bytes.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#1000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
